// File: hw/rtl/pwt_pkg.sv
// ----------------------------------------------------------------------------
// pwt_pkg
// Shared types and constants for the wire-format tokenizer: word layouts,
// token kinds, error codes, wire types and the decode phase encoding.
// ----------------------------------------------------------------------------
package pwt_pkg;

  // Width of the length/remaining-byte counter (8..64)
  localparam int LENGTH_BITS = 32;
  localparam logic [63:0] LEN_MAX =
    (LENGTH_BITS >= 64) ? 64'hFFFF_FFFF_FFFF_FFFF
                        : ((64'd1 << (LENGTH_BITS % 64)) - 64'd1);

  // Token queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QADDR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Varint limits
  localparam logic [3:0] VARINT_MAX_BYTES = 4'd10;

  // Token kinds
  localparam logic [1:0] KIND_SCALAR  = 2'd0;
  localparam logic [1:0] KIND_LEN_HDR = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_TRUNCATED = 3'd1;
  localparam logic [2:0] ERR_TOO_LONG  = 3'd2;
  localparam logic [2:0] ERR_BAD_WT    = 3'd3;
  localparam logic [2:0] ERR_RANGE     = 3'd4;

  // Wire types
  localparam logic [2:0] WT_VINT    = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LEN     = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam logic [LENGTH_BITS-1:0] FIXED64_BYTES = LENGTH_BITS'(8);
  localparam logic [LENGTH_BITS-1:0] FIXED32_BYTES = LENGTH_BITS'(4);

  // Decode phase
  typedef enum logic [2:0] {
    PH_TAG,
    PH_VARINT,
    PH_FIXED,
    PH_LENVAR,
    PH_PAYLOAD,
    PH_SKIP
  } phase_t;

  // Input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_in_message;
  } in_word_t;

  // Output word
  typedef struct packed {
    logic [1:0]  kind;
    logic [28:0] field_id;
    logic [2:0]  wtype;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    logic        last_of_field;
    logic        end_of_message;
    logic [2:0]  error_code;
  } out_word_t;

  // Raw token record from front to back; data holds value or payload byte
  typedef struct packed {
    logic [1:0]  kind;
    logic [28:0] field;
    logic [2:0]  wt;
    logic [63:0] data;
    logic        lof;
    logic        eom;
    logic [2:0]  err;
  } tok_t;

endpackage

// File: hw/rtl/protobuf_wire_tokenizer_unit.sv
// An accepted byte has its token written into the token queue, then popped into the
// output register, from which it can be taken.
// Throughput: one byte per cycle unless the queue is full; the decoder steps per byte.
// A two-entry token queue lets the decoder keep taking bytes while a result is stalled.
// Reset (rst_n low, synchronous) returns the decoder to tag phase and empties the queue
// and the output register; no clearing pass is needed.
// ----------------------------------------------------------------------------
// protobuf_wire_tokenizer_unit
// Wire-format tokenizer: byte decoder, token queue and output stage.
// ----------------------------------------------------------------------------
module protobuf_wire_tokenizer_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pwt_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output pwt_pkg::out_word_t out_word
);
  import pwt_pkg::*;

  logic q_full;
  logic q_not_empty;
  logic push;
  logic pop;
  tok_t push_tok;
  tok_t head_tok;

  // Byte decoder
  pwt_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_word  (in_word),
    .q_full   (q_full),
    .in_stall (in_stall),
    .push     (push),
    .push_tok (push_tok)
  );

  // Token queue
  pwt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tok  (push_tok),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_tok  (head_tok)
  );

  // Output stage
  pwt_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .head_tok    (head_tok),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule

// File: hw/rtl/pwt_front.sv
// ----------------------------------------------------------------------------
// pwt_front
// Takes one message byte per cycle while the queue has room, runs the
// tag/varint/fixed/length/payload decode, queueing a raw token when due.
// ----------------------------------------------------------------------------
module pwt_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  pwt_pkg::in_word_t in_word,
  input  logic              q_full,
  output logic              in_stall,
  output logic              push,
  output pwt_pkg::tok_t     push_tok
);
  import pwt_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [63:0]            acc_r, acc_nxt;
  logic [3:0]             sb_r, sb_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [28:0]            field_r, field_nxt;
  logic [2:0]             wt_r, wt_nxt;

  logic                   accept;
  logic [7:0]             b;
  logic                   last;
  logic                   cont;
  logic [6:0]             vshift_full;
  logic [63:0]            acc_var;
  logic [63:0]            acc_fix;
  logic [3:0]             sb_inc;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   rem_dec_zero;
  logic                   wt_ok;
  logic                   fn_ok;
  logic                   len_ok;
  logic                   len_zero;

  // classification of the current byte
  logic                   emit;
  logic [1:0]             emit_kind;
  logic [2:0]             err;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign b        = in_word.in_byte;
  assign last     = in_word.last_in_message;
  assign cont     = b[7];

  // Datapath: varint and little-endian merges, counters, range checks
  always_comb begin
    vshift_full  = 7'({3'b000, sb_r} * 7'd7);
    acc_var      = acc_r | (64'(b[6:0]) << vshift_full[5:0]);
    acc_fix      = acc_r | (64'(b) << {sb_r[2:0], 3'b000});
    sb_inc       = sb_r + 4'd1;
    rem_dec      = (rem_r != '0) ? (rem_r - LENGTH_BITS'(1)) : rem_r;
    rem_dec_zero = (rem_dec == '0);
    wt_ok        = (acc_var[2:0] inside {WT_VINT, WT_FIXED64, WT_LEN, WT_FIXED32});
    fn_ok        = (acc_var[63:32] == '0) && (acc_var[31:3] != '0);
    len_ok       = ((acc_var & ~LEN_MAX) == '0);
    len_zero     = (acc_var == '0);
  end

  // Classify: error code and whether a token is produced
  always_comb begin
    emit      = 1'b0;
    emit_kind = KIND_SCALAR;
    err       = ERR_NONE;
    unique case (phase_r)
      PH_TAG, PH_VARINT, PH_LENVAR: begin
        if (cont) begin
          if (sb_inc >= VARINT_MAX_BYTES) err = ERR_TOO_LONG;
          else if (last)                  err = ERR_TRUNCATED;
        end else if (phase_r == PH_TAG) begin
          if (!wt_ok)      err = ERR_BAD_WT;
          else if (!fn_ok) err = ERR_RANGE;
          else if (last)   err = ERR_TRUNCATED;
        end else if (phase_r == PH_VARINT) begin
          emit = 1'b1;
        end else begin
          if (!len_ok)                 err = ERR_RANGE;
          else if (!len_zero && last)  err = ERR_TRUNCATED;
          else begin
            emit      = 1'b1;
            emit_kind = KIND_LEN_HDR;
          end
        end
      end
      PH_FIXED: begin
        if (!rem_dec_zero && last) err = ERR_TRUNCATED;
        else if (rem_dec_zero)     emit = 1'b1;
      end
      PH_PAYLOAD: begin
        if (!rem_dec_zero && last) err = ERR_TRUNCATED;
        else begin
          emit      = 1'b1;
          emit_kind = KIND_PAYLOAD;
        end
      end
      PH_SKIP: begin
        emit = 1'b0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    sb_nxt    = sb_r;
    rem_nxt   = rem_r;
    field_nxt = field_r;
    wt_nxt    = wt_r;
    if (err != ERR_NONE) begin
      // tag fields are taken before a late truncation on the tag byte
      if (phase_r == PH_TAG && !cont && wt_ok && fn_ok) begin
        field_nxt = acc_var[31:3];
        wt_nxt    = acc_var[2:0];
      end
      phase_nxt = last ? PH_TAG : PH_SKIP;
      acc_nxt   = '0;
      sb_nxt    = '0;
      rem_nxt   = '0;
    end else begin
      unique case (phase_r)
        PH_TAG, PH_VARINT, PH_LENVAR: begin
          acc_nxt = acc_var;
          sb_nxt  = sb_inc;
          if (!cont) begin
            acc_nxt   = '0;
            sb_nxt    = '0;
            phase_nxt = PH_TAG;
            if (phase_r == PH_TAG) begin
              field_nxt = acc_var[31:3];
              wt_nxt    = acc_var[2:0];
              if (acc_var[2:0] == WT_VINT) begin
                phase_nxt = PH_VARINT;
              end else if (acc_var[2:0] == WT_LEN) begin
                phase_nxt = PH_LENVAR;
              end else begin
                phase_nxt = PH_FIXED;
                rem_nxt   = (acc_var[2:0] == WT_FIXED64) ? FIXED64_BYTES : FIXED32_BYTES;
              end
            end else if (phase_r == PH_LENVAR && !len_zero) begin
              phase_nxt = PH_PAYLOAD;
              rem_nxt   = acc_var[LENGTH_BITS-1:0];
            end
          end
        end
        PH_FIXED: begin
          acc_nxt = acc_fix;
          sb_nxt  = sb_inc;
          rem_nxt = rem_dec;
          if (rem_dec_zero) begin
            phase_nxt = PH_TAG;
            acc_nxt   = '0;
            sb_nxt    = '0;
          end
        end
        PH_PAYLOAD: begin
          rem_nxt = rem_dec;
          if (rem_dec_zero) begin
            phase_nxt = PH_TAG;
            acc_nxt   = '0;
            sb_nxt    = '0;
          end
        end
        PH_SKIP: begin
          if (last) begin
            phase_nxt = PH_TAG;
            acc_nxt   = '0;
            sb_nxt    = '0;
            rem_nxt   = '0;
          end
        end
        default: begin
          phase_nxt = PH_TAG;
        end
      endcase
    end
  end

  // Token to the queue
  always_comb begin
    push          = accept && (emit || (err != ERR_NONE));
    push_tok.kind  = (err != ERR_NONE) ? KIND_ERROR : emit_kind;
    push_tok.field = field_r;
    push_tok.wt    = wt_r;
    push_tok.data  = (phase_r == PH_FIXED) ? acc_fix :
                     (phase_r == PH_PAYLOAD) ? 64'(b) : acc_var;
    push_tok.lof   = (phase_r == PH_PAYLOAD) ? rem_dec_zero : len_zero;
    push_tok.eom   = last;
    push_tok.err   = err;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_TAG;
      acc_r   <= '0;
      sb_r    <= '0;
      rem_r   <= '0;
      field_r <= '0;
      wt_r    <= '0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      sb_r    <= sb_nxt;
      rem_r   <= rem_nxt;
      field_r <= field_nxt;
      wt_r    <= wt_nxt;
    end
  end

endmodule

// File: hw/rtl/pwt_queue.sv
// ----------------------------------------------------------------------------
// pwt_queue
// Short token FIFO that decouples the byte decoder from the output stage.
// ----------------------------------------------------------------------------
module pwt_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  pwt_pkg::tok_t push_tok,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output pwt_pkg::tok_t head_tok
);
  import pwt_pkg::*;

  tok_t                  entry_r [QUEUE_DEPTH];
  logic [QADDR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QADDR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QADDR_BITS:0]   count_r, count_nxt;

  assign full      = (count_r == (QADDR_BITS + 1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head_tok  = entry_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QADDR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                             : wr_ptr_r + QADDR_BITS'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QADDR_BITS'(QUEUE_DEPTH - 1)) ? '0
                                                             : rd_ptr_r + QADDR_BITS'(1);
    end
    if (push && !pop)      count_nxt = count_r + (QADDR_BITS + 1)'(1);
    else if (pop && !push) count_nxt = count_r - (QADDR_BITS + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// File: hw/rtl/pwt_back.sv
// ----------------------------------------------------------------------------
// pwt_back
// Output stage: pops raw tokens, shapes them into result words by kind and
// holds them in the output register until taken.
// ----------------------------------------------------------------------------
module pwt_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_not_empty,
  input  pwt_pkg::tok_t      head_tok,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output pwt_pkg::out_word_t out_word
);
  import pwt_pkg::*;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r, out_word_nxt;
  logic      is_err;

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign pop       = q_not_empty && (!out_valid_r || !out_stall);

  // Shape the token: zero the fields that do not apply to its kind
  always_comb begin
    is_err                      = (head_tok.kind == KIND_ERROR);
    out_word_nxt.kind           = head_tok.kind;
    out_word_nxt.field_id       = is_err ? '0 : head_tok.field;
    out_word_nxt.wtype          = is_err ? '0 : head_tok.wt;
    out_word_nxt.value          = '0;
    out_word_nxt.payload_byte   = '0;
    out_word_nxt.last_of_field  = 1'b0;
    out_word_nxt.end_of_message = is_err ? 1'b0 : head_tok.eom;
    out_word_nxt.error_code     = is_err ? head_tok.err : ERR_NONE;
    unique case (head_tok.kind)
      KIND_SCALAR: begin
        out_word_nxt.value = head_tok.data;
      end
      KIND_LEN_HDR: begin
        out_word_nxt.value         = head_tok.data;
        out_word_nxt.last_of_field = head_tok.lof;
      end
      KIND_PAYLOAD: begin
        out_word_nxt.payload_byte  = head_tok.data[7:0];
        out_word_nxt.last_of_field = head_tok.lof;
      end
      default: begin
        out_word_nxt.value = '0;
      end
    endcase
  end

  // Output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop)            out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word_r <= out_word_nxt;
    end
  end

endmodule
